>>> hdl/shrunk_genotype_correlation_defines.svh
// Assertion macros used by the RTL of the genotype correlation block.
`ifndef SHRUNK_GENOTYPE_CORRELATION_DEFINES_SVH
`define SHRUNK_GENOTYPE_CORRELATION_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SGC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgc assertion failed");

// The condition must hold in the cycle after the trigger.
`define SGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgc assertion failed");

`endif

>>> hdl/sgc_pkg.sv
// Package with the fixed widths, codes and reset values of the genotype correlation block.
`timescale 1ns / 1ps
`default_nettype none
package sgc_pkg;

    localparam int CMD_W      = 1;
    localparam int GENO_W     = 2;
    localparam int VARIANT_W  = 6;
    localparam int CORR_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int SC_W       = 11;
    localparam int VC_W       = 7;
    localparam int WEIGHT_W   = 17;
    localparam int WW_W       = 2 * WEIGHT_W;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CMD_W-1:0]     cmd_t;

    localparam cfg_idx_t CFG_SAMPLE_COUNT  = 2'd0;
    localparam cfg_idx_t CFG_VARIANT_COUNT = 2'd1;
    localparam cfg_idx_t CFG_SHRINK_WEIGHT = 2'd2;

    localparam cmd_t CMD_LOAD  = 1'b0;
    localparam cmd_t CMD_QUERY = 1'b1;

    localparam logic [SC_W-1:0]     SAMPLE_COUNT_RST  = 11'd1024;
    localparam logic [VC_W-1:0]     VARIANT_COUNT_RST = 7'd64;
    localparam logic [WEIGHT_W-1:0] SHRINK_WEIGHT_RST = 17'd65536;

    localparam logic [CORR_W-1:0] CORR_ONE     = 16'd32767;
    localparam logic [CORR_W-1:0] CORR_NEG_CAP = 16'd32768;

endpackage
`default_nettype wire

>>> hdl/sgc_channels.sv
// Channel interfaces for configuration writes, input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface sgc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sgc_pkg::CFG_IDX_W-1:0]     index;
    logic [sgc_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface sgc_in_if;
    logic                              valid;
    logic                              ready;
    logic [sgc_pkg::CMD_W-1:0]         command;
    logic [sgc_pkg::GENO_W-1:0]        genotype;
    logic [sgc_pkg::VARIANT_W-1:0]     variant_a;
    logic [sgc_pkg::VARIANT_W-1:0]     variant_b;
    modport source (output valid, output command, output genotype, output variant_a,
                    output variant_b, input ready);
    modport sink (input valid, input command, input genotype, input variant_a,
                  input variant_b, output ready);
endinterface

interface sgc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sgc_pkg::CORR_W-1:0] correlation;
    logic                              zero_variance;
    modport source (output valid, output correlation, output zero_variance, input ready);
    modport sink (input valid, input correlation, input zero_variance, output ready);
endinterface
`default_nettype wire

>>> hdl/shrunk_genotype_correlation.sv
// Top level of the shrunk genotype correlation block.
//
// Configuration writes arrive on cfg, which is always ready; after a write the
// input channel is held off while the derived limits settle.
// A load item on req writes one genotype at the load pointer and gives no
// result; the pointer wraps once it reaches samples times variants.
// A query walks both columns, one sample a cycle from two copies of the store,
// then forms the moments, the products and a binary search of up to 16 steps
// for the rounded value on one shift-and-add multiplier of 34 or more bit steps.
// Diagonal and out-of-range queries go straight from the check to the result.
// One item is worked on at a time and req is not ready meanwhile.
// Results wait in an output register on rsp; while the receiver stalls, loads
// are still taken and a query runs up to the point where its result is ready.
// Reset sets control registers to their reset values and the load pointer to zero;
// the store is not cleared and must be loaded before it is queried.
`timescale 1ns / 1ps
`default_nettype none
`include "shrunk_genotype_correlation_defines.svh"
module shrunk_genotype_correlation #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int MAX_VARIANTS = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sgc_cfg_if.sink    cfg,
    sgc_in_if.sink     req,
    sgc_out_if.source  rsp
);

    localparam int DEPTH  = MAX_SAMPLES * MAX_VARIANTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIM_W  = ADDR_W + 1;
    localparam int N_W    = $clog2(MAX_SAMPLES + 1);
    localparam int V_W    = $clog2(MAX_VARIANTS + 1);
    localparam int SUM_W  = $clog2(3 * MAX_SAMPLES + 1);
    localparam int SQ_W   = $clog2(9 * MAX_SAMPLES + 1);
    localparam int VAR_W  = N_W + SQ_W;
    localparam int PROD_W = 2 * VAR_W + sgc_pkg::WW_W;
    localparam int B_W    = (VAR_W > sgc_pkg::WW_W) ? VAR_W : sgc_pkg::WW_W;
    localparam int CW     = sgc_pkg::CORR_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHK    = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_MSTART = 3'd4;
    localparam logic [2:0] S_MWAIT  = 3'd5;
    localparam logic [2:0] S_SRCH   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [3:0] OP_NSAA = 4'd0;
    localparam logic [3:0] OP_SASA = 4'd1;
    localparam logic [3:0] OP_NSBB = 4'd2;
    localparam logic [3:0] OP_SBSB = 4'd3;
    localparam logic [3:0] OP_NSAB = 4'd4;
    localparam logic [3:0] OP_SASB = 4'd5;
    localparam logic [3:0] OP_VAVB = 4'd6;
    localparam logic [3:0] OP_CC   = 4'd7;
    localparam logic [3:0] OP_WW   = 4'd8;
    localparam logic [3:0] OP_RHS  = 4'd9;
    localparam logic [3:0] OP_TT   = 4'd10;
    localparam logic [3:0] OP_PTT  = 4'd11;

    logic [sgc_pkg::SC_W-1:0]     sc_reg;
    logic [sgc_pkg::VC_W-1:0]     vc_reg;
    logic [sgc_pkg::WEIGHT_W-1:0] w_reg;
    logic                         settle_reg;
    logic [N_W-1:0]               n_used_reg, n_used_next;
    logic [V_W-1:0]               v_used_reg, v_used_next;
    logic [LIM_W-1:0]             limit_reg, limit_next;
    logic [LIM_W-1:0]             ptr_reg, ptr_next;

    logic [2:0]                   state_reg, state_next;
    logic [3:0]                   op_reg, op_next;
    logic [sgc_pkg::VARIANT_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [ADDR_W-1:0]            base_a_reg, base_a_next, base_b_reg, base_b_next;
    logic [N_W-1:0]               s_reg, s_next;
    logic                         rd_pend_reg;
    logic [SUM_W-1:0]             sa_reg, sa_next, sb_reg, sb_next;
    logic [SQ_W-1:0]              saa_reg, saa_next, sbb_reg, sbb_next, sab_reg, sab_next;
    logic [PROD_W-1:0]            tmp_reg, tmp_next, p_reg, p_next, rhs_reg, rhs_next;
    logic [VAR_W-1:0]             va_reg, va_next, vb_reg, vb_next, cm_reg, cm_next;
    logic                         neg_reg, neg_next;
    logic [CW-1:0]                lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0]                res_corr_reg, res_corr_next;
    logic                         res_zv_reg, res_zv_next;
    logic                         out_valid_reg, out_valid_next;
    logic [CW-1:0]                out_corr_reg, out_corr_next;
    logic                         out_zv_reg, out_zv_next;

    logic                         in_acc, cfg_acc, wrap, wr_en;
    logic [ADDR_W-1:0]            wr_addr, rd_addr_a, rd_addr_b;
    logic [sgc_pkg::GENO_W-1:0]   ga, gb;
    logic                         mul_start, mul_done;
    logic [PROD_W-1:0]            mul_a, mul_prod;
    logic [B_W-1:0]               mul_b;
    logic [CW-1:0]                t_val;

    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid;
    assign req.ready = (state_reg == S_IDLE) && !settle_reg;
    assign in_acc    = req.valid && req.ready;

    always_comb
    begin
        if (sc_reg == '0)
        begin
            n_used_next = N_W'(1);
        end
        else if (32'(sc_reg) > 32'(MAX_SAMPLES))
        begin
            n_used_next = N_W'(MAX_SAMPLES);
        end
        else
        begin
            n_used_next = N_W'(sc_reg);
        end
        if (vc_reg == '0)
        begin
            v_used_next = V_W'(1);
        end
        else if (32'(vc_reg) > 32'(MAX_VARIANTS))
        begin
            v_used_next = V_W'(MAX_VARIANTS);
        end
        else
        begin
            v_used_next = V_W'(vc_reg);
        end
        limit_next = LIM_W'(n_used_next * v_used_next);
    end

    assign wrap     = ptr_reg >= limit_reg;
    assign wr_en    = in_acc && (req.command == sgc_pkg::CMD_LOAD);
    assign wr_addr  = wrap ? '0 : ptr_reg[ADDR_W-1:0];
    assign ptr_next = wr_en ? (wrap ? LIM_W'(1) : ptr_reg + LIM_W'(1)) : ptr_reg;

    assign rd_addr_a = base_a_reg + ADDR_W'(s_reg);
    assign rd_addr_b = base_b_reg + ADDR_W'(s_reg);

    sgc_ram #(.WIDTH(sgc_pkg::GENO_W), .DEPTH(DEPTH)) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.genotype),
        .rd_addr (rd_addr_a),
        .rd_data (ga)
    );

    sgc_ram #(.WIDTH(sgc_pkg::GENO_W), .DEPTH(DEPTH)) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.genotype),
        .rd_addr (rd_addr_b),
        .rd_data (gb)
    );

    assign t_val = CW'(({1'b0, mid_reg} << 1) - 17'd1);

    always_comb
    begin
        case (op_reg)
            OP_NSAA: begin mul_a = PROD_W'(n_used_reg); mul_b = B_W'(saa_reg); end
            OP_SASA: begin mul_a = PROD_W'(sa_reg);     mul_b = B_W'(sa_reg);  end
            OP_NSBB: begin mul_a = PROD_W'(n_used_reg); mul_b = B_W'(sbb_reg); end
            OP_SBSB: begin mul_a = PROD_W'(sb_reg);     mul_b = B_W'(sb_reg);  end
            OP_NSAB: begin mul_a = PROD_W'(n_used_reg); mul_b = B_W'(sab_reg); end
            OP_SASB: begin mul_a = PROD_W'(sa_reg);     mul_b = B_W'(sb_reg);  end
            OP_VAVB: begin mul_a = PROD_W'(va_reg);     mul_b = B_W'(vb_reg);  end
            OP_CC:   begin mul_a = PROD_W'(cm_reg);     mul_b = B_W'(cm_reg);  end
            OP_WW:   begin mul_a = PROD_W'(w_reg);      mul_b = B_W'(w_reg);   end
            OP_RHS:  begin mul_a = tmp_reg;             mul_b = rhs_reg[B_W-1:0]; end
            OP_TT:   begin mul_a = PROD_W'(t_val);      mul_b = B_W'(t_val);   end
            OP_PTT:  begin mul_a = p_reg;               mul_b = tmp_reg[B_W-1:0]; end
            default: begin mul_a = '0;                  mul_b = '0;            end
        endcase
    end

    assign mul_start = (state_reg == S_MSTART);

    sgc_mul #(.A_W(PROD_W), .B_W(B_W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        base_a_next   = base_a_reg;
        base_b_next   = base_b_reg;
        s_next        = s_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        saa_next      = saa_reg;
        sbb_next      = sbb_reg;
        sab_next      = sab_reg;
        tmp_next      = tmp_reg;
        p_next        = p_reg;
        rhs_next      = rhs_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        cm_next       = cm_reg;
        neg_next      = neg_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        res_corr_next = res_corr_reg;
        res_zv_next   = res_zv_reg;
        out_corr_next = out_corr_reg;
        out_zv_next   = out_zv_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if ((state_reg == S_READ || state_reg == S_DRAIN) && rd_pend_reg)
        begin
            sa_next  = sa_reg + SUM_W'(ga);
            sb_next  = sb_reg + SUM_W'(gb);
            saa_next = saa_reg + SQ_W'(ga) * SQ_W'(ga);
            sbb_next = sbb_reg + SQ_W'(gb) * SQ_W'(gb);
            sab_next = sab_reg + SQ_W'(ga) * SQ_W'(gb);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && req.command == sgc_pkg::CMD_QUERY)
                begin
                    a_next     = req.variant_a;
                    b_next     = req.variant_b;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (a_reg == b_reg)
                begin
                    res_corr_next = sgc_pkg::CORR_ONE;
                    res_zv_next   = 1'b0;
                    state_next    = S_DONE;
                end
                else if (32'(a_reg) >= 32'(v_used_reg) || 32'(b_reg) >= 32'(v_used_reg))
                begin
                    res_corr_next = '0;
                    res_zv_next   = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    base_a_next = ADDR_W'(a_reg * n_used_reg);
                    base_b_next = ADDR_W'(b_reg * n_used_reg);
                    s_next      = '0;
                    sa_next     = '0;
                    sb_next     = '0;
                    saa_next    = '0;
                    sbb_next    = '0;
                    sab_next    = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                s_next = s_reg + N_W'(1);
                if (s_reg == n_used_reg - N_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                op_next    = OP_NSAA;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_MSTART;
                    op_next    = op_reg + 4'd1;
                    case (op_reg) inside
                        OP_NSAA, OP_NSBB, OP_NSAB, OP_CC, OP_TT:
                        begin
                            tmp_next = mul_prod;
                        end
                        OP_SASA:
                        begin
                            va_next = VAR_W'(tmp_reg - mul_prod);
                        end
                        OP_SBSB:
                        begin
                            vb_next = VAR_W'(tmp_reg - mul_prod);
                        end
                        OP_SASB:
                        begin
                            if (tmp_reg >= mul_prod)
                            begin
                                cm_next  = VAR_W'(tmp_reg - mul_prod);
                                neg_next = 1'b0;
                            end
                            else
                            begin
                                cm_next  = VAR_W'(mul_prod - tmp_reg);
                                neg_next = 1'b1;
                            end
                            if (va_reg == '0 || vb_reg == '0)
                            begin
                                res_corr_next = '0;
                                res_zv_next   = 1'b1;
                                state_next    = S_DONE;
                            end
                        end
                        OP_VAVB:
                        begin
                            p_next = mul_prod;
                        end
                        OP_WW:
                        begin
                            rhs_next = mul_prod;
                        end
                        OP_RHS:
                        begin
                            rhs_next   = mul_prod;
                            lo_next    = '0;
                            hi_next    = neg_reg ? sgc_pkg::CORR_NEG_CAP : sgc_pkg::CORR_ONE;
                            state_next = S_SRCH;
                        end
                        OP_PTT:
                        begin
                            if (mul_prod <= rhs_reg)
                            begin
                                lo_next = mid_reg;
                            end
                            else
                            begin
                                hi_next = mid_reg - CW'(1);
                            end
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    res_corr_next = neg_reg ? CW'(17'h10000 - {1'b0, lo_reg}) : lo_reg;
                    res_zv_next   = 1'b0;
                    state_next    = S_DONE;
                end
                else
                begin
                    mid_next   = CW'(({1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1) >> 1);
                    op_next    = OP_TT;
                    state_next = S_MSTART;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_corr_next  = res_corr_reg;
                    out_zv_next    = res_zv_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg        <= sgc_pkg::SAMPLE_COUNT_RST;
            vc_reg        <= sgc_pkg::VARIANT_COUNT_RST;
            w_reg         <= sgc_pkg::SHRINK_WEIGHT_RST;
            settle_reg    <= 1'b1;
            n_used_reg    <= N_W'(MAX_SAMPLES);
            v_used_reg    <= V_W'(MAX_VARIANTS);
            limit_reg     <= LIM_W'(DEPTH);
            ptr_reg       <= '0;
            state_reg     <= S_IDLE;
            op_reg        <= OP_NSAA;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg.index)
                    sgc_pkg::CFG_SAMPLE_COUNT:  sc_reg <= cfg.data[sgc_pkg::SC_W-1:0];
                    sgc_pkg::CFG_VARIANT_COUNT: vc_reg <= cfg.data[sgc_pkg::VC_W-1:0];
                    sgc_pkg::CFG_SHRINK_WEIGHT: w_reg  <= cfg.data[sgc_pkg::WEIGHT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            settle_reg    <= cfg_acc;
            n_used_reg    <= n_used_next;
            v_used_reg    <= v_used_next;
            limit_reg     <= limit_next;
            ptr_reg       <= ptr_next;
            state_reg     <= state_next;
            op_reg        <= op_next;
            rd_pend_reg   <= (state_reg == S_READ);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        base_a_reg   <= base_a_next;
        base_b_reg   <= base_b_next;
        s_reg        <= s_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        saa_reg      <= saa_next;
        sbb_reg      <= sbb_next;
        sab_reg      <= sab_next;
        tmp_reg      <= tmp_next;
        p_reg        <= p_next;
        rhs_reg      <= rhs_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        cm_reg       <= cm_next;
        neg_reg      <= neg_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        res_corr_reg <= res_corr_next;
        res_zv_reg   <= res_zv_next;
        out_corr_reg <= out_corr_next;
        out_zv_reg   <= out_zv_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.correlation   = out_corr_reg;
    assign rsp.zero_variance = out_zv_reg;

    // The multiplier only reports completion while the sequencer waits for it.
    `SGC_ASSERT_NOW(a_mul_done_in_wait, mul_done, state_reg == S_MWAIT)
    // A finished result moves into a free output register in the next cycle.
    `SGC_ASSERT_NEXT(a_result_taken, state_reg == S_DONE && !out_valid_reg, out_valid_reg)
    // The search interval never turns empty.
    `SGC_ASSERT_NOW(a_search_bounds, state_reg == S_SRCH, lo_reg <= hi_reg)
    // The load pointer never exceeds the store depth.
    `SGC_ASSERT_NOW(a_ptr_in_store, 1'b1, ptr_reg <= LIM_W'(DEPTH))

endmodule
`default_nettype wire

>>> hdl/sgc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module sgc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hdl/sgc_mul.sv
// Shift-and-add multiplier that retires one bit of the second operand per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sgc_mul #(
    parameter int A_W = 84,
    parameter int B_W = 34
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [A_W-1:0] op_a,
    input  wire logic [B_W-1:0] op_b,
    output logic                done,
    output logic [A_W-1:0]      product
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [A_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   a_sh_reg, a_sh_next;
    logic [B_W-1:0]   b_sh_reg, b_sh_next;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(B_W - 1);
            acc_next  = '0;
            a_sh_next = op_a;
            b_sh_next = op_b;
        end
        else if (run_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_next = acc_reg + a_sh_reg;
            end
            a_sh_next = {a_sh_reg[A_W-2:0], 1'b0};
            b_sh_next = {1'b0, b_sh_reg[B_W-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire
